### hdl/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types and codes for the semaphore blocked queue table.
// ----------------------------------------------------------------------------
package sbq_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_OUT    = 2'd2,
        CMD_PEEK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_code_t;

    // datapath micro-operations; idle issues OP_LOAD on start, decide and done issue OP_NONE
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_RD_TAIL,
        OP_APPEND,
        OP_NEW,
        OP_RD_DESC,
        OP_TAKE_DESC,
        OP_RD_HEAD,
        OP_TAKE_HEAD,
        OP_UL_RD,
        OP_UL_WR,
        OP_FAIL_FREE,
        OP_FAIL_FIND
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_RD_TAIL,
        S_APPEND,
        S_NEW,
        S_RD_DESC,
        S_TAKE_DESC,
        S_RD_HEAD,
        S_TAKE_HEAD,
        S_UL_RD,
        S_UL_WR,
        S_FAIL_FREE,
        S_FAIL_FIND,
        S_DONE
    } state_t;

    typedef struct packed {
        cmd_t cmd;
        logic pid_ok;
        logic blocked;
        logic scan_done;
        logic found;
        logic free_ok;
    } dp_status_t;

endpackage

### hdl/semaphore_blocked_queue_table.sv
// Sequence: insert, remove and peek run the key scan, one descriptor per cycle through the
//   registered key read; out needs no scan and goes straight to its descriptor read.
// Insert or out refused on the pid alone skips the scan and ends with not-found status.
// Throughput: one command at a time; start is taken only while busy is low.
// Reset: rst_n clears the controller and all active/blocked bits; tables need no clearing.
// done pulses for one cycle with status/proc_valid/proc_out; the receiver cannot stall.
// ----------------------------------------------------------------------------
// semaphore_blocked_queue_table
// Active semaphore list: descriptor pool keyed by semaphore, each with a FIFO
// of blocked processes.
// ----------------------------------------------------------------------------
module semaphore_blocked_queue_table #(
    parameter int MAX_PROCS = 32,
    parameter int KEY_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] sem_key,
    input  logic [4:0]  proc_id,
    output logic        done,
    output logic [1:0]  status,
    output logic        proc_valid,
    output logic [4:0]  proc_out
);
    import sbq_pkg::*;

    // controller <-> datapath
    dp_op_t     op;
    dp_status_t st;

    // Sequencer: decide, scan keys (not for out), then link (insert), unlink (remove/out) or read the head (peek).
    sbq_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .st   (st),
        .op   (op),
        .busy (busy),
        .done (done)
    );

    // Tables: key/head/tail per descriptor, next/prev/desc per process.
    // Queues are doubly linked so an unlink from the middle needs no walk.
    sbq_dp #(.MAX_PROCS(MAX_PROCS), .KEY_BITS(KEY_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .command   (command),
        .sem_key   (sem_key),
        .proc_id   (proc_id),
        .st        (st),
        .status    (status),
        .proc_valid(proc_valid),
        .proc_out  (proc_out)
    );
endmodule

### hdl/sbq_ram.sv
// ----------------------------------------------------------------------------
// sbq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/sbq_ctrl.sv
// ----------------------------------------------------------------------------
// sbq_ctrl
// Command sequencer: steps the datapath through lookup, link and unlink.
// ----------------------------------------------------------------------------
module sbq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sbq_pkg::dp_status_t st,
    output sbq_pkg::dp_op_t     op,
    output logic                busy,
    output logic                done
);
    import sbq_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (st.cmd)
                    CMD_INSERT:
                    begin
                        state_next = (!st.pid_ok || st.blocked) ? S_FAIL_FIND : S_SCAN;
                    end
                    CMD_OUT:
                    begin
                        state_next = (!st.pid_ok || !st.blocked) ? S_FAIL_FIND : S_RD_DESC;
                    end
                    default:
                    begin
                        state_next = S_SCAN;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (st.scan_done)
                begin
                    if (st.cmd == CMD_INSERT)
                    begin
                        if (st.found)
                        begin
                            state_next = S_RD_TAIL;
                        end
                        else if (st.free_ok)
                        begin
                            state_next = S_NEW;
                        end
                        else
                        begin
                            state_next = S_FAIL_FREE;
                        end
                    end
                    else
                    begin
                        state_next = st.found ? S_RD_HEAD : S_FAIL_FIND;
                    end
                end
            end
            S_RD_TAIL:   state_next = S_APPEND;
            S_APPEND:    state_next = S_DONE;
            S_NEW:       state_next = S_DONE;
            S_RD_DESC:   state_next = S_TAKE_DESC;
            S_TAKE_DESC: state_next = S_UL_RD;
            S_RD_HEAD:   state_next = S_TAKE_HEAD;
            S_TAKE_HEAD: state_next = (st.cmd == CMD_PEEK) ? S_DONE : S_UL_RD;
            S_UL_RD:     state_next = S_UL_WR;
            S_UL_WR:     state_next = S_DONE;
            S_FAIL_FREE: state_next = S_DONE;
            S_FAIL_FIND: state_next = S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_DONE);
        case (state_reg)
            S_IDLE:      op = start ? OP_LOAD : OP_NONE;
            S_SCAN:      op = OP_SCAN;
            S_RD_TAIL:   op = OP_RD_TAIL;
            S_APPEND:    op = OP_APPEND;
            S_NEW:       op = OP_NEW;
            S_RD_DESC:   op = OP_RD_DESC;
            S_TAKE_DESC: op = OP_TAKE_DESC;
            S_RD_HEAD:   op = OP_RD_HEAD;
            S_TAKE_HEAD: op = OP_TAKE_HEAD;
            S_UL_RD:     op = OP_UL_RD;
            S_UL_WR:     op = OP_UL_WR;
            S_FAIL_FREE: op = OP_FAIL_FREE;
            S_FAIL_FIND: op = OP_FAIL_FIND;
            default:     op = OP_NONE;
        endcase
    end
endmodule

### hdl/sbq_dp.sv
// ----------------------------------------------------------------------------
// sbq_dp
// Descriptor and process tables, key scan and queue link/unlink datapath.
// ----------------------------------------------------------------------------
module sbq_dp #(
    parameter int MAX_PROCS = 32,
    parameter int KEY_BITS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sbq_pkg::dp_op_t     op,
    input  logic [1:0]          command,
    input  logic [31:0]         sem_key,
    input  logic [4:0]          proc_id,
    output sbq_pkg::dp_status_t st,
    output logic [1:0]          status,
    output logic                proc_valid,
    output logic [4:0]          proc_out
);
    import sbq_pkg::*;

    localparam int IW = $clog2(MAX_PROCS);
    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam logic [IW:0] SCAN_END = (IW+1)'(MAX_PROCS);

    cmd_t          cmd_reg;
    logic [KW-1:0] key_reg;
    logic [IW-1:0] pid_reg;
    logic          pid_ok_reg;
    logic [IW:0]   sidx_reg;
    logic [IW-1:0] cidx_reg;
    logic          cvalid_reg;
    logic          found_reg;
    logic [IW-1:0] fd_reg;
    logic          free_ok_reg;
    logic [IW-1:0] free_reg;
    logic [IW-1:0] d_reg;
    logic [IW-1:0] p_reg;
    logic [MAX_PROCS-1:0] active_reg;
    logic [MAX_PROCS-1:0] blocked_reg;
    logic [1:0]    status_reg;
    logic          pvalid_reg;
    logic [4:0]    pout_reg;

    logic [KW-1:0] key_rd;
    logic [IW-1:0] head_rd, tail_rd, next_rd, prev_rd, desc_rd;

    logic          key_we, head_we, tail_we, next_we, prev_we, desc_we;
    logic [IW-1:0] head_wa, tail_wa, next_wa, prev_wa, desc_wa;
    logic [IW-1:0] head_wd, tail_wd, next_wd, prev_wd, desc_wd;
    logic [IW-1:0] head_ra, tail_ra;
    logic          hit, is_head, is_tail;

    assign hit     = cvalid_reg && active_reg[cidx_reg] && (key_rd == key_reg);
    assign is_head = (head_rd == p_reg);
    assign is_tail = (tail_rd == p_reg);
    assign head_ra = (op == OP_RD_HEAD) ? fd_reg : d_reg;
    assign tail_ra = (op == OP_RD_TAIL) ? fd_reg : d_reg;

    always_comb
    begin
        key_we  = (op == OP_NEW);
        head_we = 1'b0; head_wa = free_reg; head_wd = pid_reg;
        tail_we = 1'b0; tail_wa = free_reg; tail_wd = pid_reg;
        next_we = 1'b0; next_wa = tail_rd;  next_wd = pid_reg;
        prev_we = 1'b0; prev_wa = pid_reg;  prev_wd = tail_rd;
        desc_we = 1'b0; desc_wa = pid_reg;  desc_wd = free_reg;
        case (op)
            OP_APPEND:
            begin
                next_we = 1'b1;
                prev_we = 1'b1;
                tail_we = 1'b1; tail_wa = fd_reg;
                desc_we = 1'b1; desc_wd = fd_reg;
            end
            OP_NEW:
            begin
                head_we = 1'b1;
                tail_we = 1'b1;
                desc_we = 1'b1;
            end
            OP_UL_WR:
            begin
                if (is_head)
                begin
                    // sole member frees the descriptor; otherwise advance head
                    head_we = !is_tail; head_wa = d_reg; head_wd = next_rd;
                end
                else
                begin
                    next_we = 1'b1; next_wa = prev_rd; next_wd = next_rd;
                    if (is_tail)
                    begin
                        tail_we = 1'b1; tail_wa = d_reg; tail_wd = prev_rd;
                    end
                    else
                    begin
                        prev_we = 1'b1; prev_wa = next_rd; prev_wd = prev_rd;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    sbq_ram #(.WIDTH(KW), .DEPTH(MAX_PROCS)) u_key (
        .clk(clk), .we(key_we), .waddr(free_reg), .wdata(key_reg),
        .raddr(sidx_reg[IW-1:0]), .rdata(key_rd));
    sbq_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_head (
        .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
        .raddr(head_ra), .rdata(head_rd));
    sbq_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_tail (
        .clk(clk), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd),
        .raddr(tail_ra), .rdata(tail_rd));
    sbq_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_next (
        .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .raddr(p_reg), .rdata(next_rd));
    sbq_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_prev (
        .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .raddr(p_reg), .rdata(prev_rd));
    sbq_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_desc (
        .clk(clk), .we(desc_we), .waddr(desc_wa), .wdata(desc_wd),
        .raddr(pid_reg), .rdata(desc_rd));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            blocked_reg <= '0;
            sidx_reg    <= '0;
            cvalid_reg  <= 1'b0;
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else
        begin
            case (op)
                OP_LOAD:
                begin
                    sidx_reg    <= '0;
                    cvalid_reg  <= 1'b0;
                    found_reg   <= 1'b0;
                    free_ok_reg <= 1'b0;
                end
                OP_SCAN:
                begin
                    cvalid_reg <= (sidx_reg != SCAN_END);
                    if (sidx_reg != SCAN_END)
                    begin
                        sidx_reg <= sidx_reg + 1'b1;
                    end
                    if (hit && !found_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (cvalid_reg && !active_reg[cidx_reg] && !free_ok_reg)
                    begin
                        free_ok_reg <= 1'b1;
                    end
                end
                OP_APPEND:
                begin
                    blocked_reg[pid_reg] <= 1'b1;
                end
                OP_NEW:
                begin
                    active_reg[free_reg] <= 1'b1;
                    blocked_reg[pid_reg] <= 1'b1;
                end
                OP_UL_WR:
                begin
                    blocked_reg[p_reg] <= 1'b0;
                    if (is_head && is_tail)
                    begin
                        active_reg[d_reg] <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                cmd_reg    <= cmd_t'(command);
                key_reg    <= sem_key[KW-1:0];
                pid_reg    <= IW'(proc_id);
                pid_ok_reg <= (32'(proc_id) < MAX_PROCS);
                status_reg <= ST_OK;
                pvalid_reg <= 1'b0;
                pout_reg   <= '0;
            end
            OP_SCAN:
            begin
                cidx_reg <= sidx_reg[IW-1:0];
                if (hit && !found_reg)
                begin
                    fd_reg <= cidx_reg;
                end
                if (cvalid_reg && !active_reg[cidx_reg] && !free_ok_reg)
                begin
                    free_reg <= cidx_reg;
                end
            end
            OP_TAKE_DESC:
            begin
                d_reg      <= desc_rd;
                p_reg      <= pid_reg;
                pvalid_reg <= 1'b1;
                pout_reg   <= 5'(pid_reg);
            end
            OP_TAKE_HEAD:
            begin
                d_reg      <= fd_reg;
                p_reg      <= head_rd;
                pvalid_reg <= 1'b1;
                pout_reg   <= 5'(head_rd);
            end
            OP_FAIL_FREE: status_reg <= ST_NO_FREE;
            OP_FAIL_FIND: status_reg <= ST_NOT_FOUND;
            default:
            begin
            end
        endcase
    end

    assign st.cmd       = cmd_reg;
    assign st.pid_ok    = pid_ok_reg;
    assign st.blocked   = pid_ok_reg && blocked_reg[pid_reg];
    assign st.scan_done = (sidx_reg == SCAN_END) && !cvalid_reg;
    assign st.found     = found_reg;
    assign st.free_ok   = free_ok_reg;

    assign status     = status_reg;
    assign proc_valid = pvalid_reg;
    assign proc_out   = pout_reg;
endmodule

### hdl/sbq_checker.sv
// ----------------------------------------------------------------------------
// sbq_checker
// Port-level checks for the semaphore blocked queue table.
// ----------------------------------------------------------------------------
module sbq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status,
    input logic       proc_valid,
    input logic [4:0] proc_out
);
    import sbq_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accept did not raise busy");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy) else $error("done not a single pulse");
    a_done_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ST_NOT_FOUND) else $error("bad status code");
    a_pout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !proc_valid |-> proc_out == 5'd0) else $error("proc_out not zero");
    a_err_novalid: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> !proc_valid) else $error("valid with error");
endmodule

bind semaphore_blocked_queue_table sbq_checker u_sbq_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .proc_valid(proc_valid), .proc_out(proc_out)
);
